// File: rtl/sads_pkg.sv
// Shared constants, codes and field widths for the dual stack.
// No dependencies; imported by the dual-stack top and the testbench.
package sads_pkg;

  localparam int STORE_DEPTH_DEF   = 128;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int VALUE_W  = 32;  // push_value / read_value
  localparam int COUNT_W  = 8;   // low_count / high_count
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

endpackage

// File: rtl/shared_array_dual_stack.sv
// Two stacks in one RAM. Push, underflow and unused actions give their result in the
// cycle after the transfer; a good pop or peek after the RAM read and the READ state. One
// push per cycle while replies are taken; a good pop or peek stalls input until its read
// is done. A new item is taken only while the output register is empty or being drained.
// Reset (rst, synchronous): both stacks empty, output channel idle. Store contents are left
// as they are: no clearing pass, an entry is only read after its stack has written it.
module shared_array_dual_stack #(
  parameter int STORE_DEPTH   = sads_pkg::STORE_DEPTH_DEF,
  parameter int ELEMENT_WIDTH = sads_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sads_pkg::ACTION_W-1:0]      action,
  input  logic                               which_stack,
  input  logic signed [sads_pkg::VALUE_W-1:0] push_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sads_pkg::VALUE_W-1:0] read_value,
  output logic [sads_pkg::STATUS_W-1:0]      status,
  output logic                               low_empty,
  output logic                               high_empty,
  output logic [sads_pkg::COUNT_W-1:0]       low_count,
  output logic [sads_pkg::COUNT_W-1:0]       high_count
);

  import sads_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);      // RAM address
  localparam int CW = $clog2(STORE_DEPTH + 1);  // element count, holds STORE_DEPTH

  typedef enum logic {IDLE, READ} state_t;

  state_t          state;
  logic [CW-1:0]   low_depth, high_depth;
  logic [CW-1:0]   low_depth_next, high_depth_next;
  logic [CW:0]     depth_sum;
  logic            full;
  logic            is_low;
  logic            sel_empty;
  logic            accept;
  logic            is_push, is_pop, is_peek;
  logic [CW-1:0]   push_idx, top_idx;
  logic            ram_en;
  logic [AW-1:0]   ram_addr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata, ram_rdata;

  // Handshake: one item in flight while a RAM read is pending.
  assign in_ready = (state == IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign is_push = (action == ACT_PUSH);
  assign is_pop  = (action == ACT_POP);
  assign is_peek = (action == ACT_PEEK);
  assign is_low  = (which_stack == SIDE_LOW);

  // Store is full when the two stacks meet
  assign depth_sum = {1'b0, low_depth} + {1'b0, high_depth};
  assign full      = (depth_sum >= (CW+1)'(STORE_DEPTH));
  assign sel_empty = is_low ? (low_depth == '0) : (high_depth == '0);

  // Next free slot and current top of the selected stack
  assign push_idx = is_low ? low_depth : (CW'(STORE_DEPTH - 1) - high_depth);
  assign top_idx  = is_low ? (low_depth - CW'(1)) : (CW'(STORE_DEPTH) - high_depth);

  assign ram_en    = accept && ((is_push && !full) || ((is_pop || is_peek) && !sel_empty));
  assign ram_addr  = is_push ? push_idx[AW-1:0] : top_idx[AW-1:0];
  assign ram_wdata = ELEMENT_WIDTH'($unsigned(push_value));

  // Pointer update at the transfer
  always_comb begin
    low_depth_next  = low_depth;
    high_depth_next = high_depth;
    if (accept) begin
      if (is_push && !full) begin
        if (is_low) low_depth_next  = low_depth + CW'(1);
        else        high_depth_next = high_depth + CW'(1);
      end else if (is_pop && !sel_empty) begin
        if (is_low) low_depth_next  = low_depth - CW'(1);
        else        high_depth_next = high_depth - CW'(1);
      end
    end
  end

  sads_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (is_push),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Control and output register. Counts are captured after the update; they do not move
  // while a read is pending since no transfer is taken then.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      low_depth  <= '0;
      high_depth <= '0;
    end else begin
      low_depth  <= low_depth_next;
      high_depth <= high_depth_next;
      case (state)
        IDLE: begin
          if (accept) begin
            low_count  <= COUNT_W'(low_depth_next);
            high_count <= COUNT_W'(high_depth_next);
            low_empty  <= (low_depth_next == '0);
            high_empty <= (high_depth_next == '0);
            read_value <= '0;
            if (is_push) begin
              out_valid <= 1'b1;
              status    <= full ? ST_OVERFLOW : ST_OK;
            end else if (is_pop || is_peek) begin
              if (sel_empty) begin
                out_valid <= 1'b1;
                status    <= ST_UNDERFLOW;
              end else begin
                out_valid <= 1'b0;
                state     <= READ;
              end
            end else begin
              // unused action code: no effect
              out_valid <= 1'b1;
              status    <= ST_OK;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        READ: begin
          out_valid  <= 1'b1;
          read_value <= VALUE_W'(ram_rdata);
          status     <= ST_OK;
          state      <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // The two stacks never hold more than the store
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    depth_sum <= (CW+1)'(STORE_DEPTH))
    else $error("stacks overlap");

  // A pending read always delivers its result next cycle
  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |=> out_valid)
    else $error("pending read lost");

  // Overflow is reported only with the store full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OVERFLOW) |-> full)
    else $error("overflow without full store");

  // A successful push grows the total by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && !full) |=> (depth_sum == $past(depth_sum) + (CW+1)'(1)))
    else $error("push did not advance pointer");

endmodule

// File: rtl/sads_ram.sv
// Generic single-port synchronous RAM, registered read.
// Standalone; no package dependency.
module sads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: tb/sv/dual_stack_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the dual-stack block: a shadow copy of both stacks and the
// queue of replies still awaited. Depends on sads_pkg for codes and widths.
package dual_stack_tb_pkg;
  import sads_pkg::*;

  // Spare action code: no effect on either stack, status ok, zero read value.
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic                      low_empty;
    logic                      high_empty;
    logic [COUNT_W-1:0]        low_count;
    logic [COUNT_W-1:0]        high_count;
  } stack_reply_t;

  class stack_scoreboard;
    logic [ELEMENT_WIDTH_DEF-1:0] store [STORE_DEPTH_DEF];
    int unsigned                  low_depth;
    int unsigned                  high_depth;
    int                           mismatches;
    stack_reply_t                 awaited_replies [$];

    function new();
      low_depth  = 0;
      high_depth = 0;
      mismatches = 0;
    endfunction

    // Shadow of one operation; returns the reply the block must give.
    function stack_reply_t apply_stack_op(logic [ACTION_W-1:0] act, logic side,
                                          logic [VALUE_W-1:0] value);
      stack_reply_t r;
      r        = '0;
      r.status = ST_OK;
      case (act)
        ACT_PUSH: begin
          if (low_depth + high_depth >= STORE_DEPTH_DEF) begin
            r.status = ST_OVERFLOW;
          end else if (side == SIDE_LOW) begin
            store[low_depth] = ELEMENT_WIDTH_DEF'(value);
            low_depth++;
          end else begin
            store[STORE_DEPTH_DEF - 1 - high_depth] = ELEMENT_WIDTH_DEF'(value);
            high_depth++;
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (side == SIDE_LOW) begin
            if (low_depth == 0) begin
              r.status = ST_UNDERFLOW;
            end else begin
              r.read_value = VALUE_W'(store[low_depth - 1]);
              if (act == ACT_POP) low_depth--;
            end
          end else begin
            if (high_depth == 0) begin
              r.status = ST_UNDERFLOW;
            end else begin
              r.read_value = VALUE_W'(store[STORE_DEPTH_DEF - high_depth]);
              if (act == ACT_POP) high_depth--;
            end
          end
        end
        default: ;
      endcase
      r.low_empty  = (low_depth == 0);
      r.high_empty = (high_depth == 0);
      r.low_count  = COUNT_W'(low_depth);
      r.high_count = COUNT_W'(high_depth);
      return r;
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic side,
                               logic [VALUE_W-1:0] value);
      awaited_replies.push_back(apply_stack_op(act, side, value));
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] seen);
      if (seen !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
      end
    endfunction

    function void check_reply(stack_reply_t seen);
      stack_reply_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none awaited, expected nothing got read_value %0h status %0d",
                 $time, seen.read_value, seen.status);
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("read_value", want.read_value, seen.read_value);
      compare_field("status",     want.status,     seen.status);
      compare_field("low_empty",  want.low_empty,  seen.low_empty);
      compare_field("high_empty", want.high_empty, seen.high_empty);
      compare_field("low_count",  want.low_count,  seen.low_count);
      compare_field("high_count", want.high_count, seen.high_count);
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_shared_array_dual_stack.sv
`timescale 1ns / 100ps
// Top-level testbench for shared_array_dual_stack: drives stack operations,
// paces both channels and checks every reply. Needs sads_pkg and dual_stack_tb_pkg.
module tb_shared_array_dual_stack;
  import sads_pkg::*;
  import dual_stack_tb_pkg::*;

  // Cycles with no transfer on either channel before the run is abandoned.
  // Gaps and stalls are geometric at worst 87 %, so a few thousand is ample.
  localparam int STALL_LIMIT   = 4000;
  // Extra cycles after the last phase, to catch a stray late reply.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_OPS     = 400;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic [ACTION_W-1:0]       action      = ACT_SPARE;
  logic                      which_stack = SIDE_LOW;
  logic signed [VALUE_W-1:0] push_value  = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic signed [VALUE_W-1:0] read_value;
  logic [STATUS_W-1:0]       status;
  logic                      low_empty;
  logic                      high_empty;
  logic [COUNT_W-1:0]        low_count;
  logic [COUNT_W-1:0]        high_count;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles       = 0;
  int ops_sent           = 0;

  stack_scoreboard board = new();

  shared_array_dual_stack dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .which_stack (which_stack),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .low_empty   (low_empty),
    .high_empty  (high_empty),
    .low_count   (low_count),
    .high_count  (high_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reply side: sample at the edge (pre-update values), then choose whether
  // to stall for the next cycle.
  always @(posedge clk) begin : reply_side
    stack_reply_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.read_value = read_value;
      seen.status     = status;
      seen.low_empty  = low_empty;
      seen.high_empty = high_empty;
      seen.low_count  = low_count;
      seen.high_count = high_count;
      board.check_reply(seen);
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // One request transfer. Called at a rising edge; returns at the edge where
  // the transfer happened. Valid is only lowered for a gap, so it is never
  // dropped and raised again within one step.
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic side,
                         input logic [VALUE_W-1:0] value);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid    <= 1'b1;
    action      <= act;
    which_stack <= side;
    push_value  <= value;
    do @(posedge clk); while (!in_ready);
    board.note_request(act, side, value);
    ops_sent++;
  endtask

  // Element values: mostly random, with the extremes mixed in.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic pick_side(int high_pct);
    return ($urandom_range(99) < high_pct);
  endfunction

  // Push until the two stacks meet, then a few refused pushes. The side bias
  // lets one stack take the whole store now and then.
  task automatic fill_store();
    int bias;
    case ($urandom_range(3))
      0:       bias = 0;
      1:       bias = 100;
      2:       bias = 50;
      default: bias = $urandom_range(100);
    endcase
    while (board.low_depth + board.high_depth < STORE_DEPTH_DEF)
      send_op(ACT_PUSH, pick_side(bias), pick_value());
    repeat ($urandom_range(1, 3)) send_op(ACT_PUSH, 1'($urandom_range(1)), pick_value());
  endtask

  // Pop both stacks down to empty, checking the LIFO order, then a few
  // reads on empty stacks.
  task automatic drain_store();
    logic                side;
    logic [ACTION_W-1:0] act;
    while (board.low_depth + board.high_depth != 0) begin
      if (board.low_depth == 0)       side = SIDE_HIGH;
      else if (board.high_depth == 0) side = SIDE_LOW;
      else                            side = 1'($urandom_range(1));
      act = ($urandom_range(9) == 0) ? ACT_PEEK : ACT_POP;
      send_op(act, side, pick_value());
    end
    repeat ($urandom_range(1, 3))
      send_op($urandom_range(1) ? ACT_POP : ACT_PEEK, 1'($urandom_range(1)), pick_value());
  endtask

  // Free mix, slightly push-heavy so the store drifts towards full.
  task automatic mixed_ops(int len);
    int                  pick;
    logic [ACTION_W-1:0] act;
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 40)      act = ACT_PUSH;
      else if (pick < 70) act = ACT_POP;
      else if (pick < 92) act = ACT_PEEK;
      else                act = ACT_SPARE;
      send_op(act, 1'($urandom_range(1)), pick_value());
    end
  endtask

  task automatic run_phase(int quota);
    int first;
    first = ops_sent;
    while (ops_sent - first < quota) begin
      case ($urandom_range(9))
        0, 1:    fill_store();
        2, 3:    drain_store();
        default: mixed_ops($urandom_range(8, 40));
      endcase
    end
  endtask

  // Hold the request side off until every awaited reply has come back.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads and spare codes on empty stacks, extreme values on
    // both sides, LIFO order, then underflow once emptied again.
    send_op(ACT_POP,   SIDE_LOW,  32'h1234_5678);
    send_op(ACT_PEEK,  SIDE_HIGH, 32'hffff_ffff);
    send_op(ACT_SPARE, SIDE_LOW,  32'h5555_5555);
    send_op(ACT_SPARE, SIDE_HIGH, 32'haaaa_aaaa);
    send_op(ACT_PUSH,  SIDE_LOW,  32'h7fff_ffff);
    send_op(ACT_PUSH,  SIDE_LOW,  32'h8000_0000);
    send_op(ACT_PUSH,  SIDE_HIGH, 32'hffff_ffff);
    send_op(ACT_PUSH,  SIDE_HIGH, 32'h0000_0000);
    send_op(ACT_PUSH,  SIDE_HIGH, 32'haaaa_5555);
    send_op(ACT_PEEK,  SIDE_LOW,  32'h0000_0000);
    send_op(ACT_PEEK,  SIDE_HIGH, 32'hffff_ffff);
    send_op(ACT_SPARE, SIDE_LOW,  32'hffff_ffff);
    send_op(ACT_POP,   SIDE_LOW,  32'h0000_0000);
    send_op(ACT_POP,   SIDE_LOW,  32'h0000_0000);
    send_op(ACT_POP,   SIDE_LOW,  32'h0000_0000);
    send_op(ACT_POP,   SIDE_HIGH, 32'h0000_0000);
    send_op(ACT_PEEK,  SIDE_HIGH, 32'h0000_0000);
    send_op(ACT_POP,   SIDE_HIGH, 32'h0000_0000);
    send_op(ACT_POP,   SIDE_HIGH, 32'h0000_0000);
    send_op(ACT_PEEK,  SIDE_HIGH, 32'h0000_0000);
    send_op(ACT_PEEK,  SIDE_LOW,  32'h0000_0000);

    // Full store and refused push guaranteed early, before the random mix.
    fill_store();

    // Pacing phases: free flow, sparse requests, heavy back-pressure, light
    // both. Each ends with the request side held until all replies are in.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      run_phase(PHASE_OPS);
      wait_for_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sads_pkg.sv
rtl/sads_ram.sv
rtl/shared_array_dual_stack.sv
tb/sv/dual_stack_scoreboard.sv
tb/sv/tb_shared_array_dual_stack.sv
